@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the heap RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/hpq_pkg.sv @@
// Types and constants of the binary max-heap priority queue.
`default_nettype none

package hpq_pkg;

	localparam int CAPACITY = 64;
	localparam int PRIO_W   = 8;
	localparam int TAG_W    = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int ENTRY_W  = PRIO_W + TAG_W;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [PRIO_W-1:0] priority_req;
		logic [TAG_W-1:0]  tag;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              top_valid;
		logic [PRIO_W-1:0] top_priority;
		logic [TAG_W-1:0]  top_tag;
	} rsp_t;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

@@ hw/rtl/hpq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module hpq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/hpq_ctrl.sv @@
// Sift engine: sequences heap inserts and removes over the entry RAM.
`default_nettype none

`include "assert_macros.svh"

module hpq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire hpq_pkg::req_t               req,
	output logic                             res_load,
	input  wire logic                        res_free,
	output hpq_pkg::rsp_t                    res,
	output logic                             ram_we,
	output logic [hpq_pkg::IDX_W-1:0]        ram_waddr,
	output hpq_pkg::entry_t                  ram_wdata,
	output logic                             ram_re,
	output logic [hpq_pkg::IDX_W-1:0]        ram_raddr,
	input  wire hpq_pkg::entry_t             ram_rdata
);

	import hpq_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;
	entry_t           x_q;
	entry_t           lft_q;
	logic             has_r_q;
	status_t          st_q;
	entry_t           top_q;

	logic             acc;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] parent;
	logic [CNT_W-1:0] left_w;
	logic [CNT_W-1:0] right_w;
	logic             up_go;
	logic             r_win;
	entry_t           big;
	logic [IDX_W-1:0] big_idx;
	logic             dn_go;

	assign acc     = req_valid && req_ready;
	assign full    = (cnt_q == CNT_W'(CAPACITY));
	assign empty   = (cnt_q == '0);
	assign parent  = (idx_q - IDX_W'(1)) >> 1;
	assign left_w  = CNT_W'({idx_q, 1'b1});
	assign right_w = left_w + CNT_W'(1);
	assign up_go   = (x_q.prio > ram_rdata.prio);
	assign r_win   = has_r_q && (ram_rdata.prio > lft_q.prio);
	assign big     = r_win ? ram_rdata : lft_q;
	assign big_idx = r_win ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
	assign dn_go   = (x_q.prio < big.prio);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (req.cmd == CMD_INSERT) begin
						state_d = full ? S_DONE : S_UP_RD;
					end else begin
						state_d = (empty || cnt_q == CNT_W'(1)) ? S_DONE : S_DN_LAST;
					end
				end
			end
			S_UP_RD:   state_d = (idx_q == '0) ? S_DONE : S_UP_CMP;
			S_UP_CMP:  state_d = up_go ? S_UP_RD : S_DONE;
			S_DN_LAST: state_d = S_DN_RDL;
			S_DN_RDL:  state_d = (left_w >= cnt_q) ? S_DONE : S_DN_RDR;
			S_DN_RDR:  state_d = S_DN_CMP;
			S_DN_CMP:  state_d = dn_go ? S_DN_RDL : S_DONE;
			S_DONE:    state_d = res_free ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		req_ready = (state_q == S_IDLE);
		res_load  = (state_q == S_DONE) && res_free;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = x_q;
		ram_re    = 1'b0;
		ram_raddr = parent;
		unique case (state_q)
			S_IDLE: begin
				if (acc && req.cmd == CMD_REMOVE && cnt_q > CNT_W'(1)) begin
					ram_re    = 1'b1;
					ram_raddr = IDX_W'(cnt_q - CNT_W'(1));
				end
			end
			S_UP_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
				end
			end
			S_UP_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = up_go ? ram_rdata : x_q;
			end
			S_DN_RDL: begin
				if (left_w >= cnt_q) begin
					ram_we = 1'b1;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = left_w[IDX_W-1:0];
				end
			end
			S_DN_RDR: begin
				ram_re    = (right_w < cnt_q);
				ram_raddr = right_w[IDX_W-1:0];
			end
			S_DN_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = dn_go ? big : x_q;
			end
			S_DN_LAST, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				if (req.cmd == CMD_INSERT && !full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else if (req.cmd == CMD_REMOVE && !empty) begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_q   <= '{prio: req.priority_req, tag: req.tag};
			idx_q <= cnt_q[IDX_W-1:0];
			if (req.cmd == CMD_INSERT) begin
				st_q <= full ? ST_FULL : ST_OK;
			end else begin
				st_q <= empty ? ST_EMPTY : ST_OK;
			end
		end
		if (state_q == S_DN_LAST) begin
			x_q   <= ram_rdata;
			idx_q <= '0;
		end
		if (state_q == S_UP_CMP && up_go) begin
			idx_q <= parent;
		end
		if (state_q == S_DN_RDR) begin
			lft_q   <= ram_rdata;
			has_r_q <= (right_w < cnt_q);
		end
		if (state_q == S_DN_CMP && dn_go) begin
			idx_q <= big_idx;
		end
		if (ram_we && ram_waddr == '0) begin
			top_q <= ram_wdata;
		end
	end

	always_comb begin
		res.status       = st_q;
		res.count        = cnt_q;
		res.top_valid    = !empty;
		res.top_priority = empty ? '0 : top_q.prio;
		res.top_tag      = empty ? '0 : top_q.tag;
	end

	`CHK_SAME(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`CHK_SAME(a_wr_in_heap, clk, arst_n, ram_we, CNT_W'(ram_waddr) < cnt_q, "write past last entry")
	`CHK_SAME(a_rd_in_heap, clk, arst_n, ram_re, CNT_W'(ram_raddr) < cnt_q, "read past last entry")
	`CHK_NEXT(a_ins_count, clk, arst_n, acc && req.cmd == CMD_INSERT && !full,
		cnt_q == $past(cnt_q) + CNT_W'(1), "insert did not grow count")

endmodule

`default_nettype wire

@@ hw/rtl/binary_max_heap_priority_queue.sv @@
// Binary max-heap priority queue: top level with entry RAM and response register.
// Usage:
//   req channel (req_valid/req_ready/req) carries one command per transaction:
//   insert an entry (priority_req, tag) or remove the top entry.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one transaction per
//   command: status, count after the command, and the current top entry
//   (top_valid low and top fields zero when the heap is empty).
//   Commands are processed one at a time; entries live in a 64-entry RAM
//   with registered read data, so the sift loop sets the time per command.
//   Insert: the entry climbs level by level while it is larger than its
//   parent, and stops there or at the root.
//   Remove: the last entry moves to the root and descends while a child is
//   larger than it, trading places with the larger child.
//   Full insert, empty remove and removing the only entry touch no RAM.
//   The response sits in an output register; the next command is taken while
//   it waits. If the receiver stalls and the register is still occupied, a
//   finished command holds in the engine and req_ready stays low.
//   Reset (arst_n low) empties the heap; RAM contents need no clearing, only
//   slots below the count are ever read.
`default_nettype none

module binary_max_heap_priority_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire hpq_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output hpq_pkg::rsp_t       rsp
);

	import hpq_pkg::*;

	logic             res_load;
	logic             res_free;
	rsp_t             res;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_rdata;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_load  (res_load),
		.res_free  (res_free),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	hpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
